// ----- hw/rtl/omb_pkg.sv -----
// Package: payload structs, opcodes, emitter phases and sequencer states.
`timescale 1ns / 1ps

package omb_pkg;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] address;
		logic [11:0] word_value;
		logic        allow_redefine;
	} in_t;

	typedef struct packed {
		logic [11:0] read_word;
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        end_of_file;
		logic        redefine_error;
	} out_t;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_DEFINE = 2'd1;
	localparam logic [1:0] OP_FETCH  = 2'd2;
	localparam logic [1:0] OP_EMIT   = 2'd3;

	localparam logic [3:0] PH_SIG0     = 4'd0;
	localparam logic [3:0] PH_SIG3     = 4'd3;
	localparam logic [3:0] PH_ENTRY_HI = 4'd4;
	localparam logic [3:0] PH_ENTRY_LO = 4'd5;
	localparam logic [3:0] PH_LENGTH   = 4'd6;
	localparam logic [3:0] PH_ADDR_HI  = 4'd7;
	localparam logic [3:0] PH_ADDR_LO  = 4'd8;
	localparam logic [3:0] PH_DATA     = 4'd9;
	localparam logic [3:0] PH_DONE     = 4'd10;

	localparam logic [5:0] HALF_MASK = 6'h3F;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DISPATCH,
		S_CLEAR,
		S_MEM_RD,
		S_MEM_USE,
		S_FIND_RD,
		S_FIND_CHK,
		S_CNT_RD,
		S_CNT_CHK,
		S_FINISH
	} state_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h4F;
			2'd1:    b = 8'h42;
			2'd2:    b = 8'h4A;
			default: b = 8'h38;
		endcase
		return b;
	endfunction

endpackage

// ----- hw/rtl/object_memory_block_emitter_core.sv -----
// Top level: word store with valid bits and object-file byte emitter.
`timescale 1ns / 1ps
// Usage
//  in_*  : one transaction per command (clear, define, fetch, emit byte).
//          Accepted when in_valid is high and in_stall low. in_stall is high
//          whenever the sequencer is busy with the previous transaction.
//  out_* : exactly one result transaction per command, from an output
//          register; the next command is taken while a result waits.
//  cfg_* : entry address write, always ready; write only while idle.
// Sequence: a signature, entry-high or address byte is answered from registers;
//  define and fetch read the addressed store entry, a data byte the word at the
//  emit position; the entry-low byte searches the store for a valid word; a length
//  byte finds the next valid word, then scans entries (the run's first word is read
//  twice) until an invalid word, MAX_BLOCK_WORDS or the end of the store; the low
//  half of a block's last word also searches for another valid word; clear writes
//  every entry. The store is single-port, one access per cycle, with every scan
//  step a read followed by a check of the registered data.
// Reset: a clearing pass over all MEM_WORDS entries zeroes every valid bit; no
//  command is accepted meanwhile. Configuration writes are taken throughout.
// A stalled receiver holds the result; the sequencer waits in its final step.
module object_memory_block_emitter_core import omb_pkg::*; #(
	parameter int MEM_WORDS       = 4096,
	parameter int MAX_BLOCK_WORDS = 126
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam int PW = AW + 1;
	localparam int CW = $clog2(MAX_BLOCK_WORDS + 1);
	localparam logic [PW-1:0] MEM_END  = PW'(MEM_WORDS);
	localparam logic [PW-1:0] MEM_LAST = PW'(MEM_WORDS - 1);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BLOCK_WORDS);

	// store: {valid, word}
	logic [12:0] mem [MEM_WORDS];
	logic [12:0] rdata_q;
	logic        mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [12:0] mem_wdata;

	state_t state_q, state_d;
	in_t    item_q;
	out_t   res_q, out_q;
	logic   out_valid_q;
	logic [11:0] entry_q;

	logic [PW-1:0] ptr_q;
	logic [PW-1:0] scan_pos_q;
	logic [3:0]    phase_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] cnt_q;
	logic          half_q;

	logic [12:0] pos13;
	logic        addr_in_range;
	logic        out_free;
	logic        last_half;

	assign pos13         = 13'(scan_pos_q);
	assign addr_in_range = {1'b0, item_q.address} < 13'(MEM_WORDS);
	assign out_free      = !out_valid_q || !out_stall;
	assign last_half     = (run_q <= CW'(1));

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and store port control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = ptr_q[AW-1:0];
		mem_wdata = '0;
		case (state_q)
			S_INIT, S_CLEAR: begin
				mem_we = 1'b1;
				if (ptr_q == MEM_LAST) begin
					state_d = (state_q == S_INIT) ? S_IDLE : S_FINISH;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (item_q.opcode)
					OP_CLEAR:  state_d = S_CLEAR;
					OP_DEFINE, OP_FETCH: state_d = addr_in_range ? S_MEM_RD : S_FINISH;
					default: begin
						case (phase_q)
							PH_ENTRY_LO, PH_LENGTH: state_d = S_FIND_RD;
							PH_DATA:                state_d = S_MEM_RD;
							default:                state_d = S_FINISH;
						endcase
					end
				endcase
			end
			S_MEM_RD: begin
				mem_re   = 1'b1;
				mem_addr = (item_q.opcode == OP_EMIT) ? scan_pos_q[AW-1:0]
					: item_q.address[AW-1:0];
				state_d  = S_MEM_USE;
			end
			S_MEM_USE: begin
				if (item_q.opcode == OP_DEFINE) begin
					mem_we    = 1'b1;
					mem_addr  = item_q.address[AW-1:0];
					mem_wdata = {1'b1, item_q.word_value};
					state_d   = S_FINISH;
				end else if (item_q.opcode == OP_EMIT && half_q && last_half) begin
					state_d = S_FIND_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FIND_RD: begin
				if (ptr_q >= MEM_END) begin
					state_d = S_FINISH;
				end else begin
					mem_re  = 1'b1;
					state_d = S_FIND_CHK;
				end
			end
			S_FIND_CHK: begin
				if (rdata_q[12]) begin
					state_d = (phase_q == PH_LENGTH) ? S_CNT_RD : S_FINISH;
				end else begin
					state_d = S_FIND_RD;
				end
			end
			S_CNT_RD: begin
				if (cnt_q == CNT_MAX || ptr_q >= MEM_END) begin
					state_d = S_FINISH;
				end else begin
					mem_re  = 1'b1;
					state_d = S_CNT_CHK;
				end
			end
			S_CNT_CHK: begin
				state_d = rdata_q[12] ? S_CNT_RD : S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// item, result and emitter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			scan_pos_q  <= '0;
			phase_q     <= PH_SIG0;
			run_q       <= '0;
			cnt_q       <= '0;
			half_q      <= 1'b0;
			entry_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				entry_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT, S_CLEAR: begin
					ptr_q <= (ptr_q == MEM_LAST) ? '0 : ptr_q + PW'(1);
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						res_q  <= '0;
					end
				end
				S_DISPATCH: begin
					if (item_q.opcode == OP_CLEAR) begin
						ptr_q      <= '0;
						scan_pos_q <= '0;
						phase_q    <= PH_SIG0;
						run_q      <= '0;
						half_q     <= 1'b0;
					end else if (item_q.opcode == OP_EMIT) begin
						if (phase_q <= PH_SIG3) begin
							res_q.out_byte   <= sig_byte(phase_q[1:0]);
							res_q.byte_valid <= 1'b1;
							phase_q          <= phase_q + 4'd1;
						end else begin
							case (phase_q)
								PH_ENTRY_HI: begin
									res_q.out_byte   <= {2'b00, entry_q[11:6]};
									res_q.byte_valid <= 1'b1;
									phase_q          <= PH_ENTRY_LO;
								end
								PH_ENTRY_LO: begin
									res_q.out_byte   <= {2'b00, entry_q[5:0] & HALF_MASK};
									res_q.byte_valid <= 1'b1;
									ptr_q            <= '0;
								end
								PH_LENGTH: ptr_q <= scan_pos_q;
								PH_ADDR_HI: begin
									res_q.out_byte   <= {2'b00, pos13[11:6]};
									res_q.byte_valid <= 1'b1;
									phase_q          <= PH_ADDR_LO;
								end
								PH_ADDR_LO: begin
									res_q.out_byte   <= {2'b00, pos13[5:0]};
									res_q.byte_valid <= 1'b1;
									phase_q          <= PH_DATA;
								end
								default: ;
							endcase
						end
					end
				end
				S_MEM_USE: begin
					case (item_q.opcode)
						OP_DEFINE: res_q.redefine_error <= rdata_q[12] && !item_q.allow_redefine;
						OP_FETCH:  res_q.read_word <= rdata_q[12] ? rdata_q[11:0] : 12'd0;
						OP_EMIT: begin
							res_q.byte_valid <= 1'b1;
							if (!half_q) begin
								res_q.out_byte <= {2'b00, rdata_q[11:6]};
								half_q         <= 1'b1;
							end else begin
								res_q.out_byte <= {2'b00, rdata_q[5:0]};
								half_q         <= 1'b0;
								scan_pos_q     <= scan_pos_q + PW'(1);
								ptr_q          <= scan_pos_q + PW'(1);
								if (run_q != '0) begin
									run_q <= run_q - CW'(1);
								end
							end
						end
						default: ;
					endcase
				end
				S_FIND_RD: begin
					if (ptr_q >= MEM_END) begin
						// nothing valid ahead
						phase_q <= PH_DONE;
						if (phase_q != PH_LENGTH) begin
							res_q.end_of_file <= 1'b1;
						end
					end
				end
				S_FIND_CHK: begin
					if (rdata_q[12]) begin
						if (phase_q == PH_LENGTH) begin
							scan_pos_q <= ptr_q;
							cnt_q      <= '0;
						end else begin
							if (phase_q == PH_ENTRY_LO) begin
								scan_pos_q <= '0;
							end
							phase_q <= PH_LENGTH;
						end
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_CNT_RD: begin
					if (cnt_q == CNT_MAX || ptr_q >= MEM_END) begin
						run_q            <= cnt_q;
						half_q           <= 1'b0;
						res_q.out_byte   <= 8'({cnt_q, 1'b0}) + 8'd3;
						res_q.byte_valid <= 1'b1;
						phase_q          <= PH_ADDR_HI;
					end
				end
				S_CNT_CHK: begin
					if (rdata_q[12]) begin
						cnt_q <= cnt_q + CW'(1);
						ptr_q <= ptr_q + PW'(1);
					end else begin
						run_q            <= cnt_q;
						half_q           <= 1'b0;
						res_q.out_byte   <= 8'({cnt_q, 1'b0}) + 8'd3;
						res_q.byte_valid <= 1'b1;
						phase_q          <= PH_ADDR_HI;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// checks
	a_eof_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.end_of_file || out_data.byte_valid))
		else $error("end_of_file without a byte");
	a_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.byte_valid && (out_data.read_word != 12'd0
			|| out_data.redefine_error)))
		else $error("emit result mixes fetch or define fields");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_MAX) && (run_q <= CNT_MAX))
		else $error("block word count beyond limit");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && !out_free) |=> (state_q == S_FINISH))
		else $error("result step left while output held");

endmodule

// ----- bench/tb.sv -----
// Testbench for object_memory_block_emitter_core: commands checked against a predictor.
`timescale 1ns / 1ps

module tb;
	import omb_pkg::*;

	localparam int WORDS  = 4096;
	localparam int MAXBLK = 126;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [11:0] cfg_data;

	object_memory_block_emitter_core #(
		.MEM_WORDS(WORDS),
		.MAX_BLOCK_WORDS(MAXBLK)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the block: word store, valid bits, emitter position, entry register.
	logic [11:0] shadow_words [WORDS];
	bit          shadow_valid [WORDS];
	int unsigned scan_pos;
	logic [3:0]  phase;
	int unsigned run_left;
	bit          low_half;
	logic [11:0] entry_addr;

	out_t owed_results [$];
	int   fail_count;
	bit   send_gaps;
	bit   recv_gaps;
	int   stall_left;

	always #2 clk = ~clk;

	// Pass the rest of a mismatch along with the field name; one line each.
	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("%0t mismatch on %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
	endtask

	function automatic int unsigned next_valid(input int unsigned pos);
		while (pos < WORDS && !shadow_valid[pos])
			pos++;
		return pos;
	endfunction

	function automatic void restart_emitter();
		scan_pos = 0;
		phase    = PH_SIG0;
		run_left = 0;
		low_half = 0;
	endfunction

	// Signature bytes, written out here rather than borrowed from the package.
	function automatic logic [7:0] sig_ref(input logic [1:0] k);
		logic [7:0] s [4];
		s = '{8'h4F, 8'h42, 8'h4A, 8'h38};
		return s[k];
	endfunction

	// Next object-file byte, advancing the shadow emitter.
	function automatic out_t next_file_byte();
		out_t        r;
		int unsigned start;
		int unsigned n;
		logic [11:0] w;
		r = '0;
		r.byte_valid = 1'b1;
		if (phase < PH_ENTRY_HI) begin
			r.out_byte = sig_ref(phase[1:0]);
			phase++;
		end else if (phase == PH_ENTRY_HI) begin
			r.out_byte = {2'b00, entry_addr[11:6]};
			phase = PH_ENTRY_LO;
		end else if (phase == PH_ENTRY_LO) begin
			r.out_byte = {2'b00, entry_addr[5:0]};
			if (next_valid(0) >= WORDS) begin
				r.end_of_file = 1'b1;
				phase = PH_DONE;
			end else begin
				scan_pos = 0;
				phase = PH_LENGTH;
			end
		end else if (phase == PH_LENGTH) begin
			start = next_valid(scan_pos);
			if (start >= WORDS) begin
				phase = PH_DONE;
				r.byte_valid = 1'b0;
			end else begin
				n = 0;
				while (n < MAXBLK && start + n < WORDS && shadow_valid[start + n])
					n++;
				scan_pos   = start;
				run_left   = n;
				low_half   = 0;
				r.out_byte = 8'(2 * n + 3);
				phase      = PH_ADDR_HI;
			end
		end else if (phase == PH_ADDR_HI) begin
			r.out_byte = 8'((scan_pos >> 6) & 'h3F);
			phase = PH_ADDR_LO;
		end else if (phase == PH_ADDR_LO) begin
			r.out_byte = 8'(scan_pos & 'h3F);
			phase = PH_DATA;
		end else if (phase == PH_DATA) begin
			w = shadow_words[scan_pos];
			if (!low_half) begin
				r.out_byte = {2'b00, w[11:6]};
				low_half = 1;
			end else begin
				r.out_byte = {2'b00, w[5:0]};
				low_half = 0;
				scan_pos++;
				if (run_left > 0)
					run_left--;
				if (run_left == 0) begin
					if (next_valid(scan_pos) >= WORDS) begin
						r.end_of_file = 1'b1;
						phase = PH_DONE;
					end else begin
						phase = PH_LENGTH;
					end
				end
			end
		end else begin
			r.byte_valid = 1'b0;
		end
		return r;
	endfunction

	// Expected result of one command; updates the shadow state.
	function automatic out_t command_result(input in_t c);
		out_t r;
		r = '0;
		case (c.opcode)
			OP_CLEAR: begin
				foreach (shadow_valid[i])
					shadow_valid[i] = 0;
				restart_emitter();
			end
			OP_DEFINE: begin
				r.redefine_error = shadow_valid[c.address] && !c.allow_redefine;
				shadow_valid[c.address] = 1;
				shadow_words[c.address] = c.word_value;
			end
			OP_FETCH: begin
				if (shadow_valid[c.address])
					r.read_word = shadow_words[c.address];
			end
			default: r = next_file_byte();
		endcase
		return r;
	endfunction

	// Drive one command at the falling edge and hold it until accepted.
	task automatic send_cmd(input in_t c);
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do @(posedge clk); while (in_stall);
		owed_results.push_back(command_result(c));
	endtask

	task automatic send_op(input logic [1:0] op, input logic [11:0] addr = '0,
			input logic [11:0] val = '0, input logic allow = 1'b0);
		in_t c;
		c.opcode         = op;
		c.address        = addr;
		c.word_value     = val;
		c.allow_redefine = allow;
		send_cmd(c);
	endtask

	// Stop sending and wait until every owed result has come back, plus slack.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_results.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_entry(input logic [11:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		entry_addr = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic emit_to_end(input int extra);
		while (phase != PH_DONE)
			send_op(OP_EMIT);
		repeat (extra) send_op(OP_EMIT);
	endtask

	// Empty file, signature, redefine rules, fetch of both ends of the store.
	task automatic test_directed();
		write_entry(12'hFFF);
		emit_to_end(2);
		send_op(OP_FETCH, 12'd0);
		send_op(OP_DEFINE, 12'd0, 12'hFFF, 1'b0);
		send_op(OP_DEFINE, 12'd0, 12'hABC, 1'b0);   // redefine error
		send_op(OP_DEFINE, 12'd0, 12'h5A5, 1'b1);   // allowed overwrite
		send_op(OP_DEFINE, 12'hFFF, 12'h000, 1'b1);
		send_op(OP_FETCH, 12'd0);
		send_op(OP_FETCH, 12'hFFF);
		send_op(OP_CLEAR);
		send_op(OP_FETCH, 12'd0);                    // cleared word reads as 0
		send_op(OP_DEFINE, 12'd1, 12'h041);
		send_op(OP_DEFINE, 12'd2, 12'hFC0);
		send_op(OP_DEFINE, 12'hFFF, 12'h7FF);
		write_entry(12'h000);
		emit_to_end(1);
		send_op(OP_DEFINE, 12'd3, 12'h123);         // after end of file: nothing more
		send_op(OP_EMIT);
	endtask

	// A run of 128 words at the top of the store is split into 126 and 2.
	task automatic test_long_run();
		send_op(OP_CLEAR);
		write_entry(12'h800);
		for (int a = WORDS - 128; a < WORDS; a++)
			send_op(OP_DEFINE, 12'(a), 12'($urandom), 1'($urandom));
		emit_to_end(1);
	endtask

	// Random files: short runs of random words, fetches, defines ahead of and behind
	// the emitter, and some stray commands.
	task automatic test_random_files(input int rounds, input bit quiet);
		int          runs;
		int          len;
		logic [11:0] base;
		logic [11:0] defined [$];
		for (int r = 0; r < rounds; r++) begin
			send_gaps = !quiet;
			recv_gaps = !quiet;
			defined.delete();
			if (r % 3 == 0)
				send_op(OP_CLEAR);
			case (r % 4)
				0: write_entry(12'h000);
				1: write_entry(12'hFFF);
				default: write_entry(12'($urandom));
			endcase
			runs = $urandom_range(1, 4);
			for (int k = 0; k < runs; k++) begin
				len  = $urandom_range(1, 6);
				base = ($urandom_range(0, 4) == 0) ? 12'(WORDS - len) : 12'($urandom);
				for (int j = 0; j < len && base + j < WORDS; j++) begin
					send_op(OP_DEFINE, 12'(base + j), 12'($urandom), 1'($urandom));
					defined.push_back(12'(base + j));
				end
				if ($urandom_range(0, 2) == 0)
					send_op(OP_DEFINE, defined[$urandom_range(0, defined.size() - 1)],
						12'($urandom), 1'($urandom));
			end
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 1))
					send_op(OP_FETCH, defined[$urandom_range(0, defined.size() - 1)]);
				else
					send_op(OP_FETCH, 12'($urandom));
			end
			if (r == 1)
				drain();   // let the block go fully quiet mid-sequence
			while (phase != PH_DONE) begin
				case ($urandom_range(0, 11))
					0: send_op(OP_DEFINE, 12'($urandom), 12'($urandom), 1'($urandom));
					1: send_op(OP_FETCH, 12'($urandom), 12'($urandom), 1'($urandom));
					default: send_op(OP_EMIT, 12'($urandom), 12'($urandom), 1'($urandom));
				endcase
			end
			send_op(OP_EMIT);
		end
	endtask

	// Receiver stall bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_results.size() == 0) begin
				report_mismatch("unexpected transaction", out_data, 0);
			end else begin
				want = owed_results.pop_front();
				if (out_data.read_word != want.read_word)
					report_mismatch("read_word", out_data.read_word, want.read_word);
				if (out_data.out_byte != want.out_byte)
					report_mismatch("out_byte", out_data.out_byte, want.out_byte);
				if (out_data.byte_valid != want.byte_valid)
					report_mismatch("byte_valid", out_data.byte_valid, want.byte_valid);
				if (out_data.end_of_file != want.end_of_file)
					report_mismatch("end_of_file", out_data.end_of_file, want.end_of_file);
				if (out_data.redefine_error != want.redefine_error)
					report_mismatch("redefine_error", out_data.redefine_error,
						want.redefine_error);
			end
		end
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		stall_left = 0;
		fail_count = 0;
		send_gaps  = 1'b1;
		recv_gaps  = 1'b1;
		foreach (shadow_valid[i])
			shadow_valid[i] = 0;
		entry_addr = '0;
		restart_emitter();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_long_run();
		test_random_files(2, 1'b0);
		test_random_files(1, 1'b1);   // closing stretch without random send or receive gaps

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("object_memory_block_emitter_core test passed");
		else
			$display("object_memory_block_emitter_core test failed");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("object_memory_block_emitter_core test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/omb_pkg.sv
hw/rtl/object_memory_block_emitter_core.sv
bench/tb.sv
